[rtl/ipv6c_pkg.sv]
`default_nettype none
package ipv6c_pkg;

  localparam int NUM_GROUPS = 8;
  localparam int GROUP_W    = 16;
  localparam int GRP_IW     = $clog2(NUM_GROUPS);
  localparam int GRP_CW     = $clog2(NUM_GROUPS + 1);

  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_COLON = 8'h3a;

  typedef struct packed {
    logic              compress;
    logic [GRP_IW-1:0] start;
    logic [GRP_CW-1:0] len;
  } run_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CHAR_0 + {4'b0000, nib};
    end
    return CHAR_A + {4'b0000, nib} - 8'd10;
  endfunction

endpackage
`default_nettype wire

[rtl/ipv6c_addr_if.sv]
`default_nettype none
interface ipv6c_addr_if;
  logic        valid;
  logic        ready;
  logic [15:0] group_0;
  logic [15:0] group_1;
  logic [15:0] group_2;
  logic [15:0] group_3;
  logic [15:0] group_4;
  logic [15:0] group_5;
  logic [15:0] group_6;
  logic [15:0] group_7;

  modport source (
    output valid, group_0, group_1, group_2, group_3,
           group_4, group_5, group_6, group_7,
    input  ready
  );
  modport sink (
    input  valid, group_0, group_1, group_2, group_3,
           group_4, group_5, group_6, group_7,
    output ready
  );
endinterface
`default_nettype wire

[rtl/ipv6c_char_if.sv]
`default_nettype none
interface ipv6c_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;

  modport source (output valid, text_char, last_char, input ready);
  modport sink (input valid, text_char, last_char, output ready);
endinterface
`default_nettype wire

[rtl/ipv6c_run_finder.sv]
`default_nettype none
module ipv6c_run_finder import ipv6c_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NUM_GROUPS-1:0] zero_flags,
  output logic                  done,
  output run_t                  run
);

  logic              busy;
  logic [GRP_CW-1:0] idx;
  logic [GRP_CW-1:0] cnt;
  logic [GRP_CW-1:0] longest;
  logic [GRP_IW-1:0] best_start;
  logic              best_int;

  logic at_end;
  logic zero;
  logic interior;
  logic take;

  // one group per cycle through a single compare/update step
  always_comb begin
    at_end   = (idx == GRP_CW'(NUM_GROUPS));
    zero     = !at_end && zero_flags[idx[GRP_IW-1:0]];
    interior = (idx != cnt) && !at_end;
    // later run wins a tie unless it would trade an interior run for an end one
    take     = (cnt >= GRP_CW'(2)) &&
               ((cnt > longest) || ((cnt == longest) && (interior || !best_int)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      idx        <= '0;
      cnt        <= '0;
      longest    <= '0;
      best_start <= '0;
      best_int   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy       <= 1'b1;
        idx        <= '0;
        cnt        <= '0;
        longest    <= '0;
        best_start <= '0;
        best_int   <= 1'b0;
      end else if (busy) begin
        if (zero) begin
          cnt <= cnt + GRP_CW'(1);
        end else begin
          if (take) begin
            longest    <= cnt;
            best_start <= GRP_IW'(idx - cnt);
            best_int   <= interior;
          end
          cnt <= '0;
        end
        if (at_end) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          idx <= idx + GRP_CW'(1);
        end
      end
    end
  end

  assign run.compress = (longest >= GRP_CW'(2));
  assign run.start    = best_start;
  assign run.len      = longest;

endmodule
`default_nettype wire

[rtl/ipv6c_text_emitter.sv]
`default_nettype none
module ipv6c_text_emitter import ipv6c_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  run_t                run,
  output logic [GRP_IW-1:0]   rd_index,
  input  logic [GROUP_W-1:0]  rd_group,
  output logic                busy,
  ipv6c_char_if.source        text
);

  typedef enum logic [2:0] {E_IDLE, E_SEP, E_DIG, E_DC1, E_DC2} em_state_t;

  em_state_t         state;
  logic [GRP_CW-1:0] g;
  logic [1:0]        nib;
  logic              started;
  logic              out_valid;
  logic [7:0]        out_char;
  logic              out_last;

  logic [3:0]        nib_val;
  logic              show;
  logic              emit_now;
  logic [7:0]        emit_char;
  logic              is_last;
  logic              adv;
  logic [GRP_CW-1:0] run_end;

  function automatic em_state_t enter_state(input logic [GRP_CW-1:0] gn, input logic need);
    if (run.compress && (gn == GRP_CW'(run.start))) begin
      return E_DC1;
    end
    if (need) begin
      return E_SEP;
    end
    return E_DIG;
  endfunction

  assign rd_index = g[GRP_IW-1:0];
  assign run_end  = GRP_CW'(run.start) + run.len;
  assign adv      = !out_valid || text.ready;
  assign busy     = (state != E_IDLE);

  always_comb begin
    nib_val   = rd_group[{nib, 2'b00} +: 4];
    show      = (nib_val != 4'd0) || started || (nib == 2'd0);
    emit_now  = 1'b0;
    emit_char = CHAR_COLON;
    case (state)
      E_SEP, E_DC1, E_DC2: emit_now = 1'b1;
      E_DIG: begin
        emit_now  = show;
        emit_char = hex_char(nib_val);
      end
      default: emit_now = 1'b0;
    endcase
    is_last = ((state == E_DIG) && (nib == 2'd0) && (g == GRP_CW'(NUM_GROUPS - 1))) ||
              ((state == E_DC2) && (run_end == GRP_CW'(NUM_GROUPS)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_IDLE;
      out_valid <= 1'b0;
      g         <= '0;
      nib       <= 2'd3;
      started   <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= emit_now;
        if (emit_now) begin
          out_char <= emit_char;
          out_last <= is_last;
        end
      end
      case (state)
        E_IDLE: begin
          if (start) begin
            g       <= '0;
            nib     <= 2'd3;
            started <= 1'b0;
            state   <= enter_state('0, 1'b0);
          end
        end
        E_SEP: begin
          if (adv) state <= E_DIG;
        end
        E_DIG: begin
          if (adv) begin
            if (nib == 2'd0) begin
              if (g == GRP_CW'(NUM_GROUPS - 1)) begin
                state <= E_IDLE;
              end else begin
                g       <= g + GRP_CW'(1);
                nib     <= 2'd3;
                started <= 1'b0;
                state   <= enter_state(g + GRP_CW'(1), 1'b1);
              end
            end else begin
              nib     <= nib - 2'd1;
              started <= started | show;
            end
          end
        end
        E_DC1: begin
          if (adv) state <= E_DC2;
        end
        E_DC2: begin
          if (adv) begin
            if (run_end == GRP_CW'(NUM_GROUPS)) begin
              state <= E_IDLE;
            end else begin
              g       <= run_end;
              nib     <= 2'd3;
              started <= 1'b0;
              state   <= enter_state(run_end, 1'b0);
            end
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  assign text.valid     = out_valid;
  assign text.text_char = out_char;
  assign text.last_char = out_last;

endmodule
`default_nettype wire

[rtl/ipv6_address_text_compressor_core.sv]
`default_nettype none
// channel  dir  word                              handshake
// addr     in   group_0 .. group_7, 16 bit each   valid / ready
// text     out  text_char (8 bit), last_char      valid / ready
//
// One address at a time: the address is loaded, the zero run is scanned and handed
// over, then the sequencer steps through every hex nibble slot (leading zeros
// included) and every colon, and the core goes back to idle.
// The scan compare unit and the nibble-by-nibble text sequencer do this work.
// rst is synchronous and clears all control state. A stalled text output holds
// the sequencer; addr.ready is high only between addresses.
module ipv6_address_text_compressor_core import ipv6c_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ipv6c_addr_if.sink   addr,
  ipv6c_char_if.source text
);

  typedef enum logic [1:0] {S_IDLE, S_FIND, S_EMIT} top_state_t;

  top_state_t          state;
  logic [GROUP_W-1:0]  held_groups [NUM_GROUPS];
  logic [GROUP_W-1:0]  in_groups   [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] zero_flags;

  logic              accept;
  logic              find_done;
  logic              emit_start;
  logic              emit_busy;
  run_t              run;
  logic [GRP_IW-1:0] rd_index;
  logic [GROUP_W-1:0] rd_group;

  always_comb begin
    in_groups[0] = addr.group_0;
    in_groups[1] = addr.group_1;
    in_groups[2] = addr.group_2;
    in_groups[3] = addr.group_3;
    in_groups[4] = addr.group_4;
    in_groups[5] = addr.group_5;
    in_groups[6] = addr.group_6;
    in_groups[7] = addr.group_7;
  end

  assign addr.ready = (state == S_IDLE);
  assign accept     = addr.valid && addr.ready;
  assign emit_start = (state == S_FIND) && find_done;
  assign rd_group   = held_groups[rd_index];

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NUM_GROUPS; i++) begin
        held_groups[i] <= in_groups[i];
        zero_flags[i]  <= (in_groups[i] == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (accept) state <= S_FIND;
        S_FIND: if (find_done) state <= S_EMIT;
        S_EMIT: if (!emit_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  ipv6c_run_finder u_finder (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .zero_flags (zero_flags),
    .done       (find_done),
    .run        (run)
  );

  ipv6c_text_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .start    (emit_start),
    .run      (run),
    .rd_index (rd_index),
    .rd_group (rd_group),
    .busy     (emit_busy),
    .text     (text)
  );

endmodule
`default_nettype wire
